FILE: hdl/sfs_pkg.sv
`default_nettype none
package sfs_pkg;

  localparam int TURN = 23040;
  localparam int HALF_TURN = 11520;
  localparam int DIV_BITS = 41;

  typedef enum logic [1:0] {
    P_STOP  = 2'd0,
    P_HOLD  = 2'd1,
    P_FIRE  = 2'd2,
    P_STUCK = 2'd3
  } proc_t;

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_HOLD   = 3'd1,
    MODE_AUTO   = 3'd2,
    MODE_SINGLE = 3'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_HEAT_MARGIN = 3'd0,
    CFG_MAX_RATE    = 3'd1,
    CFG_INTERVAL    = 3'd2,
    CFG_TIMEOUT     = 3'd3,
    CFG_STEP        = 3'd4,
    CFG_TOLERANCE   = 3'd5,
    CFG_STUCK_SPEED = 3'd6,
    CFG_FRICTION    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_UPDATE,
    C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/sfs_ctrl.sv
`default_nettype none
module sfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  input  wire sfs_pkg::dp_stat_t stat,
  output sfs_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   out_load
);
  import sfs_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    busy = (state != C_IDLE);
    case (state)
      C_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = C_DIV;
        end
      end
      C_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_done) state_next = C_UPDATE;
      end
      C_UPDATE: begin
        cmd.update = 1'b1;
        state_next = C_OUT;
      end
      C_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/sfs_dp.sv
`default_nettype none
module sfs_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfs_pkg::dp_cmd_t   cmd,
  output sfs_pkg::dp_stat_t       stat,
  input  wire logic [2:0]         mode_cmd,
  input  wire logic [7:0]         bullet_speed,
  input  wire logic [15:0]        heat_now,
  input  wire logic [15:0]        heat_max,
  input  wire logic [14:0]        loader_angle,
  input  wire logic signed [15:0] loader_speed,
  input  wire logic [15:0]        heat_margin,
  input  wire logic [7:0]         max_shot_rate,
  input  wire logic [15:0]        shot_interval,
  input  wire logic [15:0]        stuck_timeout,
  input  wire logic [14:0]        loader_step,
  input  wire logic [13:0]        arrive_tolerance,
  input  wire logic signed [15:0] stuck_speed,
  input  wire logic [9:0]         friction_scale,
  output logic [15:0]             friction_ref,
  output logic                    loader_enable,
  output logic [14:0]             loader_ref,
  output logic [1:0]              process_state
);
  import sfs_pkg::*;

  // latched item
  logic [2:0] mode;
  logic [7:0] speed;
  logic [15:0] hnow, hmax;
  logic [14:0] angle;
  logic signed [15:0] lspeed;

  // state
  proc_t process;
  logic fired_mark;
  logic [14:0] loader_target;
  logic [15:0] interval_count, jam_count;

  // restoring divider: mag (41b) / den (18b)
  logic [DIV_BITS-1:0] quo;
  logic [17:0] rem;
  logic [17:0] den;
  logic [5:0] cnt;
  logic neg;
  logic [18:0] rem_sh;
  logic [19:0] rem_try;

  logic signed [17:0] diff;
  logic [17:0] diff_mag;
  logic [40:0] mag_init;

  assign diff = $signed({2'b00, hnow} << 1) - $signed({2'b00, hmax});
  assign diff_mag = diff[17] ? 18'(-diff) : diff;
  assign mag_init = 41'({max_shot_rate, 8'd0}) * 41'(diff_mag);

  assign rem_sh = {rem, quo[DIV_BITS-1]};
  assign rem_try = {1'b0, rem_sh} - {2'b00, den};
  assign stat.div_done = (cnt == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= mode_cmd;
      speed <= bullet_speed;
      hnow <= heat_now;
      hmax <= heat_max;
      angle <= loader_angle;
      lspeed <= loader_speed;
    end
  end

  // one step to load the operands, then one step per quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= 6'(DIV_BITS + 1);
    end else if (cmd.step && cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den <= 18'(heat_max) + {1'b0, heat_margin, 1'b0};
      rem <= '0;
    end else if (cmd.step && cnt == 6'(DIV_BITS + 1)) begin
      quo <= mag_init;
      neg <= diff[17];
      rem <= '0;
    end else if (cmd.step && cnt != 6'd0) begin
      if (!rem_try[19]) begin
        rem <= rem_try[17:0];
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[17:0];
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // rate evaluation
  logic [16:0] top;
  logic rate_low;
  assign top = {1'b0, max_shot_rate, 8'd0};
  always_comb begin
    logic signed [43:0] r;
    if (den == 18'd0) r = 44'(signed'({1'b0, top}));
    else if (neg) r = 44'(signed'({1'b0, top})) + 44'(signed'({3'b000, quo}));
    else r = 44'(signed'({1'b0, top})) - 44'(signed'({3'b000, quo}));
    rate_low = (r < 44'sd256);
  end

  function automatic logic arrived_f(input logic [14:0] a, input logic [14:0] t,
                                     input logic [13:0] tol);
    logic signed [15:0] d;
    logic [15:0] m;
    d = $signed({1'b0, a}) - $signed({1'b0, t});
    m = d[15] ? 16'(-d) : 16'(d);
    // angles past half a turn fold the other way
    if (m >= 16'(HALF_TURN)) m = (m <= 16'(TURN)) ? 16'(TURN) - m : m - 16'(TURN);
    return m < {2'b00, tol};
  endfunction

  function automatic logic [14:0] wrap_f(input logic signed [16:0] a);
    logic signed [16:0] v;
    v = a;
    if (v >= 17'sd23040) v = v - 17'sd23040;
    if (v < 0) v = v + 17'sd23040;
    return v[14:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      process <= P_STOP;
      fired_mark <= 1'b0;
      loader_target <= '0;
      interval_count <= '0;
      jam_count <= '0;
    end else if (cmd.update) begin
      proc_t p;
      logic fm, arr, heat_ok;
      logic [14:0] tgt;
      logic [15:0] ic, jc;
      logic [25:0] fr;
      logic [15:0] fq;
      logic [14:0] ref_v;
      p = process; fm = fired_mark; tgt = loader_target;
      ic = interval_count; jc = jam_count;
      heat_ok = ($signed({1'b0, hmax}) - $signed({1'b0, hnow}))
                > $signed({1'b0, heat_margin});
      if (ic != 16'hFFFF) ic = ic + 16'd1;
      if (rate_low) ic = '0;
      else if (ic > shot_interval) ic = shot_interval;
      if (mode == MODE_STOP) p = P_STOP;
      else if (mode == MODE_HOLD) p = P_HOLD;
      else if ((mode == MODE_AUTO || mode == MODE_SINGLE) && heat_ok &&
               p == P_HOLD && ic == shot_interval) begin
        p = P_FIRE;
        ic = '0;
      end
      arr = arrived_f(angle, tgt, arrive_tolerance);
      if (fm && p == P_FIRE) begin
        if (arr) begin
          fm = 1'b0; tgt = angle; p = P_HOLD; jc = '0;
        end else if (lspeed < stuck_speed) begin
          if (jc != 16'hFFFF) jc = jc + 16'd1;
        end
        if (jc > stuck_timeout) begin
          jc = '0; p = P_STUCK;
        end
      end else if (fm && p == P_STUCK) begin
        if (arr) begin
          fm = 1'b0; p = P_HOLD;
        end else begin
          if (jc != 16'hFFFF) jc = jc + 16'd1;
          if (jc > stuck_timeout) begin
            jc = '0; p = P_HOLD; fm = 1'b0;
          end
        end
      end
      fr = 26'(speed) * 26'(friction_scale);
      fq = (fr > 26'hFFFF) ? 16'hFFFF : fr[15:0];
      ref_v = tgt;
      if (p == P_STOP) fq = '0;
      else if (p == P_FIRE) begin
        ref_v = wrap_f(17'(tgt) + 17'(loader_step));
        fm = 1'b1;
      end else if (p == P_STUCK) begin
        ref_v = wrap_f(17'(tgt) - 17'(loader_step));
        fm = 1'b1;
      end
      friction_ref <= fq;
      loader_ref <= ref_v;
      loader_enable <= (p != P_STOP);
      process_state <= p;
      process <= p; fired_mark <= fm; loader_target <= tgt;
      interval_count <= ic; jam_count <= jc;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/shooter_feed_sequencer.sv
// the input beat is taken in the idle state; the divide state then loads the operands,
// runs the 41 shift steps of the serial rate divider and checks done, followed by an
// update state and an output state; a new item is taken only while idle, and a result
// waiting on the output holds the block in its output state until it is taken
// reset (rst, synchronous, active high) returns registers to defaults, process to stop,
// and clears fired mark, loader target and both counters
`default_nettype none
module shooter_feed_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode_cmd[2:0], bullet_speed[10:3], heat_now[26:11], heat_max[42:27],
  // loader_angle[57:43], loader_speed[73:58]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // friction_ref[15:0], loader_enable[16], loader_ref[31:17], process_state[33:32]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sfs_pkg::*;

  logic [15:0] heat_margin, shot_interval, stuck_timeout;
  logic [7:0] max_shot_rate;
  logic [14:0] loader_step;
  logic [13:0] arrive_tolerance;
  logic signed [15:0] stuck_speed;
  logic [9:0] friction_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_margin <= 16'd10;
      max_shot_rate <= 8'd20;
      shot_interval <= 16'd50;
      stuck_timeout <= 16'd500;
      loader_step <= 15'd2880;
      arrive_tolerance <= 14'd320;
      stuck_speed <= 16'sd100;
      friction_scale <= 10'd500;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEAT_MARGIN: heat_margin <= cfg_data;
        CFG_MAX_RATE:    max_shot_rate <= cfg_data[7:0];
        CFG_INTERVAL:    shot_interval <= cfg_data;
        CFG_TIMEOUT:     stuck_timeout <= cfg_data;
        CFG_STEP:        loader_step <= cfg_data[14:0];
        CFG_TOLERANCE:   arrive_tolerance <= cfg_data[13:0];
        CFG_STUCK_SPEED: stuck_speed <= cfg_data;
        CFG_FRICTION:    friction_scale <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_stat_t stat;
  logic busy, out_load, in_fire;
  logic [15:0] friction_ref;
  logic loader_enable;
  logic [14:0] loader_ref;
  logic [1:0] process_state;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  sfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .stat(stat), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  sfs_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .mode_cmd(s_axis_tdata[2:0]), .bullet_speed(s_axis_tdata[10:3]),
    .heat_now(s_axis_tdata[26:11]), .heat_max(s_axis_tdata[42:27]),
    .loader_angle(s_axis_tdata[57:43]), .loader_speed(s_axis_tdata[73:58]),
    .heat_margin(heat_margin), .max_shot_rate(max_shot_rate),
    .shot_interval(shot_interval), .stuck_timeout(stuck_timeout),
    .loader_step(loader_step), .arrive_tolerance(arrive_tolerance),
    .stuck_speed(stuck_speed), .friction_scale(friction_scale),
    .friction_ref(friction_ref), .loader_enable(loader_enable),
    .loader_ref(loader_ref), .process_state(process_state)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load)
      m_axis_tdata <= {6'd0, process_state, loader_ref, loader_enable, friction_ref};
  end

  logic unused;
  assign unused = ^s_axis_tdata[79:74];
endmodule
`default_nettype wire
